// ===== src/modbus_speed_command_framer_macros.svh =====
// Assertion macros used by the checker file.
// Both sample on the rising edge of clk and stay quiet while arst_n is low.
`ifndef MODBUS_SPEED_COMMAND_FRAMER_MACROS_SVH
`define MODBUS_SPEED_COMMAND_FRAMER_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define MSF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that cond never holds at a clock edge outside reset.
`define MSF_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== src/msf_pkg.sv =====
package msf_pkg;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_STOP  = 2'd1,
		MODE_SPEED = 2'd2,
		MODE_POLL  = 2'd3
	} mode_t;

	localparam int unsigned CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_REG  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FLOOR = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CEIL  = 4'd3;

	localparam logic [7:0]  RST_SLAVE_ADDR  = 8'd1;
	localparam logic [15:0] RST_TARGET_REG  = 16'h6000;
	localparam logic [15:0] RST_SPEED_FLOOR = 16'd2000;
	localparam logic [15:0] RST_SPEED_CEIL  = 16'd4800;
	localparam logic [15:0] RST_SPEED       = 16'd2000;

	localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;

	// Position of each byte within the frame
	localparam logic [2:0] BYTE_SLAVE   = 3'd0;
	localparam logic [2:0] BYTE_FUNC    = 3'd1;
	localparam logic [2:0] BYTE_REG_HI  = 3'd2;
	localparam logic [2:0] BYTE_REG_LO  = 3'd3;
	localparam logic [2:0] BYTE_VAL_HI  = 3'd4;
	localparam logic [2:0] BYTE_VAL_LO  = 3'd5;
	localparam logic [2:0] BYTE_CRC_LO  = 3'd6;
	localparam logic [2:0] BYTE_CRC_HI  = 3'd7;

	typedef struct packed {
		logic [7:0]  slave_addr;
		logic [15:0] target_reg;
		logic [15:0] value;
	} frame_desc_t;

	typedef struct packed {
		logic        push;
		frame_desc_t desc;
	} q_wr_t;

	typedef struct packed {
		logic        valid;
		logic        full;
		frame_desc_t head;
	} q_rd_t;

	// One byte of CRC-16/Modbus, reflected, LSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== src/modbus_speed_command_framer.sv =====
// Channel   Direction  Handshake            Words
// command   in         push / full          mode, speed_request
// frame     out        empty / pop          tx_byte, frame_end
// config    in         cfg_we (no wait)     cfg_index, cfg_data
//
// A command word is taken whenever push is high and full is low; full
// rises only while the frame queue holds QUEUE_DEPTH frames to be sent.
// A poll that finds a change yields 8 frame words, one per cycle while pop
// is high, set by the byte sequencer in the back end, which folds each of
// the first six bytes into the CRC. A frame's first word passes through
// the queue and then the output register. Reset clears the run target and
// loads the speed target with its default; it also empties the queue and
// the output stage. A low pop with a word shown stalls the byte sequencer;
// the command side keeps going until the queue fills.
module modbus_speed_command_framer #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [msf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    mode,
	input  logic [15:0]                   speed_request,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    tx_byte,
	output logic                          frame_end
);
	import msf_pkg::*;

	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_pop;

	// Front end: hold config and targets, classify each command word,
	// push a frame descriptor when a poll finds a change.
	msf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.mode          (mode),
		.speed_request (speed_request),
		.q_full        (q_rd.full),
		.full          (full),
		.q_wr          (q_wr)
	);

	// Frame descriptors waiting for the serializer
	msf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.pop    (q_pop),
		.rd     (q_rd)
	);

	// Back end: advance through the eight frame bytes, drop the descriptor
	// as the CRC high byte is loaded.
	msf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_rd.valid),
		.q_head    (q_rd.head),
		.pop       (pop),
		.q_pop     (q_pop),
		.empty     (empty),
		.tx_byte   (tx_byte),
		.frame_end (frame_end)
	);

endmodule

// ===== src/msf_front.sv =====
module msf_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [msf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                    cfg_data,
	input  logic                           push,
	input  logic [1:0]                     mode,
	input  logic [15:0]                    speed_request,
	input  logic                           q_full,
	output logic                           full,
	output msf_pkg::q_wr_t                 q_wr
);
	import msf_pkg::*;

	logic [7:0]  slave_address_q;
	logic [15:0] target_register_q;
	logic [15:0] speed_floor_q;
	logic [15:0] speed_ceiling_q;
	logic        run_target_q;
	logic [15:0] speed_target_q;
	logic        sent_run_q;
	logic [15:0] sent_speed_q;

	logic        accept;
	logic        changed;
	logic [15:0] ceil_req;
	logic [15:0] clamped;
	mode_t       mode_in;

	assign mode_in  = mode_t'(mode);
	assign full     = q_full;
	assign accept   = push && !q_full;
	assign changed  = (run_target_q != sent_run_q) || (speed_target_q != sent_speed_q);
	// ceiling first, floor wins
	assign ceil_req = (speed_request > speed_ceiling_q) ? speed_ceiling_q : speed_request;
	assign clamped  = (ceil_req < speed_floor_q) ? speed_floor_q : ceil_req;

	assign q_wr.push            = accept && (mode_in == MODE_POLL) && changed;
	assign q_wr.desc.slave_addr = slave_address_q;
	assign q_wr.desc.target_reg = target_register_q;
	assign q_wr.desc.value      = run_target_q ? speed_target_q : 16'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q   <= RST_SLAVE_ADDR;
			target_register_q <= RST_TARGET_REG;
			speed_floor_q     <= RST_SPEED_FLOOR;
			speed_ceiling_q   <= RST_SPEED_CEIL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SLAVE_ADDR:  slave_address_q   <= cfg_data[7:0];
				CFG_TARGET_REG:  target_register_q <= cfg_data;
				CFG_SPEED_FLOOR: speed_floor_q     <= cfg_data;
				CFG_SPEED_CEIL:  speed_ceiling_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_target_q   <= 1'b0;
			speed_target_q <= RST_SPEED;
			sent_run_q     <= 1'b0;
			sent_speed_q   <= RST_SPEED;
		end else if (accept) begin
			unique case (mode_in)
				MODE_START: run_target_q   <= 1'b1;
				MODE_STOP:  run_target_q   <= 1'b0;
				MODE_SPEED: speed_target_q <= clamped;
				MODE_POLL: begin
					if (changed) begin
						sent_run_q   <= run_target_q;
						sent_speed_q <= speed_target_q;
					end
				end
			endcase
		end
	end

endmodule

// ===== src/msf_queue.sv =====
module msf_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  msf_pkg::q_wr_t wr,
	input  logic           pop,
	output msf_pkg::q_rd_t rd
);
	import msf_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	frame_desc_t        mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign rd.full  = (count_q == CNT_W'(DEPTH));
	assign rd.valid = (count_q != '0);
	assign rd.head  = mem_q[rd_ptr_q];
	assign do_push  = wr.push && !rd.full;
	assign do_pop   = pop && rd.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr.desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/msf_back.sv =====
module msf_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  msf_pkg::frame_desc_t  q_head,
	input  logic                  pop,
	output logic                  q_pop,
	output logic                  empty,
	output logic [7:0]            tx_byte,
	output logic                  frame_end
);
	import msf_pkg::*;

	logic        out_valid_q;
	logic [7:0]  tx_byte_q;
	logic        frame_end_q;
	logic [2:0]  cnt_q;
	logic [15:0] crc_q;
	logic        advance;
	logic [7:0]  next_byte;
	logic [15:0] crc_base;

	assign advance  = q_valid && (!out_valid_q || pop);
	assign q_pop    = advance && (cnt_q == BYTE_CRC_HI);
	assign crc_base = (cnt_q == BYTE_SLAVE) ? CRC_INIT : crc_q;

	always_comb begin
		unique case (cnt_q)
			BYTE_SLAVE:  next_byte = q_head.slave_addr;
			BYTE_FUNC:   next_byte = FUNC_WRITE_SINGLE;
			BYTE_REG_HI: next_byte = q_head.target_reg[15:8];
			BYTE_REG_LO: next_byte = q_head.target_reg[7:0];
			BYTE_VAL_HI: next_byte = q_head.value[15:8];
			BYTE_VAL_LO: next_byte = q_head.value[7:0];
			BYTE_CRC_LO: next_byte = crc_q[7:0];
			BYTE_CRC_HI: next_byte = crc_q[15:8];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= BYTE_SLAVE;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			cnt_q       <= cnt_q + 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// crc_q is sent out at the two CRC positions, after six updates
	always_ff @(posedge clk) begin
		if (advance) begin
			tx_byte_q   <= next_byte;
			frame_end_q <= (cnt_q == BYTE_CRC_HI);
		end
		if (advance && (cnt_q < BYTE_CRC_LO)) begin
			crc_q <= crc_byte(crc_base, next_byte);
		end
	end

	assign empty     = !out_valid_q;
	assign tx_byte   = tx_byte_q;
	assign frame_end = frame_end_q;

endmodule

// ===== src/msf_checker.sv =====
`include "modbus_speed_command_framer_macros.svh"

module msf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] tx_byte,
	input logic       frame_end
);
	import msf_pkg::*;

	logic [2:0] pos_q;
	logic       out_take;

	assign out_take = pop && !empty;

	// Track the position of the shown word within its frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= BYTE_SLAVE;
		end else if (out_take) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	`MSF_ASSERT(a_hold_word, (!empty && !pop) |=> (!empty && $stable(tx_byte) && $stable(frame_end)), "output word changed while stalled")
	`MSF_ASSERT(a_end_position, !empty |-> (frame_end == (pos_q == BYTE_CRC_HI)), "frame_end not on eighth word")
	`MSF_ASSERT(a_func_code, (!empty && pos_q == BYTE_FUNC) |-> (tx_byte == FUNC_WRITE_SINGLE), "second word is not the function code")
	`MSF_ASSERT_NEVER(a_end_unknown, !empty && $isunknown(frame_end), "frame_end unknown while shown")

endmodule

bind modbus_speed_command_framer msf_checker u_msf_checker (.*);

// ===== bench/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import msf_pkg::*;

	localparam int RESET_CYCLES    = 6;
	// Quiet cycles after the last frame word before the next register write,
	// long enough for any command still in the pipe to land.
	localparam int SETTLE_CYCLES   = 16;
	// Receiver blackout used to back the frame queue up into the command side.
	localparam int HOLD_OFF_CYCLES = 250;
	// Cycles with no word moving on either side before the run is called hung.
	localparam int STALL_LIMIT     = 3000;
	localparam int FRAME_WORDS     = 8;
	localparam int PRINT_CAP       = 100;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	// Tracks run and speed targets, predicts the frames a poll must emit and
	// checks every popped word against the oldest predicted byte.
	class speed_frame_tracker;
		logic [7:0]  slave_addr;
		logic [15:0] target_reg;
		logic [15:0] speed_floor;
		logic [15:0] speed_ceil;
		logic        run_target;
		logic [15:0] speed_target;
		logic        sent_run;
		logic [15:0] sent_speed;
		frame_byte_t pending_bytes[$];
		int          mismatch_count;

		function new();
			slave_addr     = RST_SLAVE_ADDR;
			target_reg     = RST_TARGET_REG;
			speed_floor    = RST_SPEED_FLOOR;
			speed_ceil     = RST_SPEED_CEIL;
			run_target     = 1'b0;
			speed_target   = RST_SPEED;
			sent_run       = 1'b0;
			sent_speed     = RST_SPEED;
			mismatch_count = 0;
		endfunction

		function int pending();
			return pending_bytes.size();
		endfunction

		// Indexes past the last register are dropped; values are cut to width.
		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			case (idx)
				CFG_SLAVE_ADDR:  slave_addr  = data[7:0];
				CFG_TARGET_REG:  target_reg  = data;
				CFG_SPEED_FLOOR: speed_floor = data;
				CFG_SPEED_CEIL:  speed_ceil  = data;
				default: ;
			endcase
		endfunction

		function void take_command(logic [1:0] code, logic [15:0] request);
			logic [15:0] clamped;
			logic [15:0] value;
			logic [15:0] crc;
			logic [7:0]  frame [FRAME_WORDS];
			clamped = request;
			case (mode_t'(code))
				MODE_START: run_target = 1'b1;
				MODE_STOP:  run_target = 1'b0;
				MODE_SPEED: begin
					// ceiling first, floor last: the floor wins when they cross
					if (clamped > speed_ceil)
						clamped = speed_ceil;
					if (clamped < speed_floor)
						clamped = speed_floor;
					speed_target = clamped;
				end
				MODE_POLL: begin
					if (run_target != sent_run || speed_target != sent_speed) begin
						value = run_target ? speed_target : 16'h0000;
						frame[BYTE_SLAVE]  = slave_addr;
						frame[BYTE_FUNC]   = FUNC_WRITE_SINGLE;
						frame[BYTE_REG_HI] = target_reg[15:8];
						frame[BYTE_REG_LO] = target_reg[7:0];
						frame[BYTE_VAL_HI] = value[15:8];
						frame[BYTE_VAL_LO] = value[7:0];
						// reflected CRC, shift right, LSB decides the xor
						crc = CRC_INIT;
						for (int k = 0; k < BYTE_CRC_LO; k++) begin
							crc = crc ^ {8'h00, frame[k]};
							for (int b = 0; b < 8; b++)
								crc = {1'b0, crc[15:1]} ^ (crc[0] ? CRC_POLY : 16'h0000);
						end
						frame[BYTE_CRC_LO] = crc[7:0];
						frame[BYTE_CRC_HI] = crc[15:8];
						sent_run   = run_target;
						sent_speed = speed_target;
						for (int k = 0; k < FRAME_WORDS; k++)
							pending_bytes.push_back(frame_byte_t'{frame[k], k == BYTE_CRC_HI});
					end
				end
			endcase
		endfunction

		task report_mismatch(string what);
			if (mismatch_count < PRINT_CAP)
				$display("%0t mismatch: %s", $realtime, what);
			mismatch_count++;
		endtask

		task check_byte(logic [7:0] data, logic last);
			frame_byte_t want;
			if (pending_bytes.size() == 0) begin
				report_mismatch($sformatf("word %h/%b with no frame byte pending", data, last));
			end else begin
				want = pending_bytes.pop_front();
				if (data !== want.data)
					report_mismatch($sformatf("tx_byte %h, want %h", data, want.data));
				if (last !== want.last)
					report_mismatch($sformatf("frame_end %b, want %b", last, want.last));
			end
		endtask
	endclass

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = CFG_SLAVE_ADDR;
	logic [15:0]          cfg_data      = 16'h0000;
	logic                 push          = 1'b0;
	logic                 full;
	logic [1:0]           mode          = MODE_POLL;
	logic [15:0]          speed_request = 16'h0000;
	logic                 empty;
	logic                 pop           = 1'b0;
	logic [7:0]           tx_byte;
	logic                 frame_end;

	speed_frame_tracker frame_tracker;
	bit                 steady          = 1'b0;
	int                 hold_off_cycles = 0;
	int                 stalled_cycles  = 0;

	modbus_speed_command_framer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.speed_request(speed_request),
		.empty        (empty),
		.pop          (pop),
		.tx_byte      (tx_byte),
		.frame_end    (frame_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gap length for either side: mostly none or short, now and then long.
	// While steady is set both sides run flat out.
	function automatic int idle_len();
		int pick;
		if (steady)
			return 0;
		pick = $urandom_range(99);
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	// Sample both handshakes on the edge, feed the tracker, and watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				frame_tracker.take_command(mode, speed_request);
			if (pop && !empty)
				frame_tracker.check_byte(tx_byte, frame_end);
			if ((push && !full) || (pop && !empty))
				stalled_cycles = 0;
			else
				stalled_cycles++;
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("%0t no word moved for %0d cycles", $realtime, STALL_LIMIT);
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// Frame receiver: pop one word, then maybe stall. A requested hold-off
	// drops pop for a long stretch so the queue backs up into the command side.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				pop <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end
			pop <= 1'b1;
			do
				@(posedge clk);
			while (empty);
			stall = idle_len();
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Offer one command word and hold it until taken. Keep push high when no
	// gap follows so back-to-back words never drop and raise it in one step.
	task automatic send_command(input mode_t code, input logic [15:0] request);
		int gap;
		push          <= 1'b1;
		mode          <= code;
		speed_request <= request;
		do
			@(posedge clk);
		while (full);
		gap = idle_len();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop push, let every predicted byte drain, then give the block time
	// to finish any command that produced no frame.
	task automatic drain_and_settle();
		push  <= 1'b0;
		steady = 1'b0;
		while (frame_tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		frame_tracker.set_register(idx, data);
	endtask

	// Write all four registers back to back, plus one write to an unused
	// index that must leave everything alone. Hold the enable across them.
	task automatic program_registers(input logic [15:0] slave_word, input logic [15:0] reg_word,
			input logic [15:0] floor_word, input logic [15:0] ceil_word);
		logic [CFG_IDX_W-1:0] spare;
		spare = CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, CFG_SPEED_CEIL + 1));
		write_register(spare, 16'($urandom));
		write_register(CFG_SLAVE_ADDR, slave_word);
		write_register(CFG_TARGET_REG, reg_word);
		write_register(CFG_SPEED_FLOOR, floor_word);
		write_register(CFG_SPEED_CEIL, ceil_word);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Speed requests lean on the clamp edges of the current setting.
	function automatic logic [15:0] pick_speed();
		logic [15:0] lo;
		logic [15:0] hi;
		lo = frame_tracker.speed_floor;
		hi = frame_tracker.speed_ceil;
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return lo + 16'($urandom_range(10)) - 16'd5;
			2: return hi + 16'($urandom_range(10)) - 16'd5;
			default: return (lo <= hi) ? 16'($urandom_range(hi, lo)) : lo;
		endcase
	endfunction

	// Random commands, weighted toward speed settings and polls so most polls
	// find a change and frames keep coming. Flip into flat-out runs at times.
	task automatic random_commands(input int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(29) == 0)
				steady = !steady;
			pick = $urandom_range(99);
			if (pick < 12)
				send_command(MODE_START, 16'($urandom));
			else if (pick < 20)
				send_command(MODE_STOP, 16'($urandom));
			else if (pick < 58)
				send_command(MODE_SPEED, pick_speed());
			else
				send_command(MODE_POLL, 16'($urandom));
		end
	endtask

	task automatic directed_commands();
		// polls with nothing changed, speed equal to target: no frame
		send_command(MODE_POLL, 16'hFFFF);
		send_command(MODE_SPEED, RST_SPEED);
		send_command(MODE_POLL, 16'h0000);
		// start: frame at the reset speed, then a quiet poll
		send_command(MODE_START, 16'h0000);
		send_command(MODE_POLL, 16'h0000);
		send_command(MODE_POLL, 16'h0000);
		// zero clamps up to the floor, which is already the target
		send_command(MODE_SPEED, 16'h0000);
		send_command(MODE_POLL, 16'h0000);
		// all ones clamps down to the ceiling
		send_command(MODE_SPEED, 16'hFFFF);
		send_command(MODE_POLL, 16'h0000);
		// two settings before a poll: only the last counts
		send_command(MODE_SPEED, 16'd3000);
		send_command(MODE_SPEED, 16'd3001);
		send_command(MODE_POLL, 16'h0000);
		// stop sends value zero
		send_command(MODE_STOP, 16'hFFFF);
		send_command(MODE_POLL, 16'h0000);
		// speed change while stopped still sends a frame carrying zero
		send_command(MODE_SPEED, 16'd4000);
		send_command(MODE_POLL, 16'h0000);
		// start then stop again before the poll: nothing changed
		send_command(MODE_START, 16'h0000);
		send_command(MODE_STOP, 16'h0000);
		send_command(MODE_POLL, 16'h0000);
		// run again at the speed set while stopped
		send_command(MODE_START, 16'h0000);
		send_command(MODE_POLL, 16'h0000);
	endtask

	initial begin
		logic [15:0] a;
		logic [15:0] b;
		frame_tracker = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings
		directed_commands();
		random_commands(60);

		// lowest address and register, widest clamp window
		drain_and_settle();
		program_registers(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
		steady = 1'b1;
		random_commands(30);
		steady = 1'b0;
		random_commands(30);

		// address beyond the legal range with upper data bits set, top
		// register, floor above ceiling
		drain_and_settle();
		program_registers(16'hFFFF, 16'hFFFF, 16'd5000, 16'd1000);
		random_commands(50);

		// back the queue up: stop popping while polls keep finding changes
		drain_and_settle();
		program_registers(16'($urandom_range(247)), 16'($urandom), 16'h0000, 16'hFFFF);
		hold_off_cycles = HOLD_OFF_CYCLES;
		steady = 1'b1;
		send_command(MODE_START, 16'($urandom));
		for (int n = 0; n < 15; n++) begin
			send_command(MODE_SPEED, 16'($urandom));
			send_command(MODE_POLL, 16'($urandom));
		end
		steady = 1'b0;

		// random ordered window
		drain_and_settle();
		a = 16'($urandom);
		b = 16'($urandom);
		program_registers(16'($urandom), 16'($urandom), (a < b) ? a : b, (a < b) ? b : a);
		random_commands(60);

		// floor at the top, ceiling at zero: every setting lands on the floor
		drain_and_settle();
		program_registers(16'($urandom_range(247)), 16'($urandom), 16'hFFFF, 16'h0000);
		random_commands(50);

		drain_and_settle();
		if (frame_tracker.mismatch_count == 0 && frame_tracker.pending() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/msf_pkg.sv
src/msf_front.sv
src/msf_queue.sv
src/msf_back.sv
src/modbus_speed_command_framer.sv
src/msf_checker.sv
bench/testbench.sv
